@@ src/grw_pkg.sv @@
// Shared types and constants for the grid ray wall marcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package grw_pkg;

  // Map geometry: 64 x 64 cells, 16384 world units per cell, 14 fraction bits.
  localparam int unsigned MAP_DIM    = 64;
  localparam int unsigned MAP_AW     = 6;
  localparam int unsigned CELL_SHIFT = 14;
  localparam int unsigned RAM_DEPTH  = MAP_DIM * MAP_DIM;
  localparam int unsigned RAM_AW     = 2 * MAP_AW;

  // Working widths of the march coordinates and the distance unit.
  localparam int unsigned COORD_W  = 22;
  localparam int unsigned STEP_W   = 21;
  localparam int unsigned ABS_W    = 22;
  localparam int unsigned SQ_W     = 46;
  localparam int unsigned ROOT_W   = 23;
  localparam int unsigned ROOT_CW  = 5;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned DIST_W   = 28;

  localparam logic [DIST_W-1:0] NO_HIT_DIST = 28'd256000000;
  localparam logic [DIST_W-1:0] DIST_MAX    = '1;

  // Command codes of an input transaction.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PLAYER_X   = 2'd2;
  localparam logic [1:0] REG_PLAYER_Y   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic wr_cell;
    logic load;
    logic step;
    logic set_hit;
    logic sq_x;
    logic sq_y;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_map;
    logic wall;
    logic limit;
    logic sqrt_busy;
    logic out_free;
  } status_t;

endpackage

@@ src/grw_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the wall map.
module grw_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/grw_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on grw_pkg for its widths.
module grw_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [grw_pkg::SQ_W-1:0]   operand_i,
  output logic                       busy_o,
  output logic [grw_pkg::ROOT_W-1:0] root_o
);

  localparam int unsigned RemW = grw_pkg::ROOT_W + 2;

  logic                         busy_q, busy_d;
  logic [grw_pkg::ROOT_CW-1:0]  cnt_q, cnt_d;
  logic [grw_pkg::SQ_W-1:0]     op_q, op_d;
  logic [RemW-1:0]              rem_q, rem_d;
  logic [grw_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [RemW-1:0]              rem_sh;
  logic [RemW-1:0]              trial;

  // One restoring step: bring down two bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_q[RemW-3:0], op_q[grw_pkg::SQ_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = grw_pkg::ROOT_CW'(grw_pkg::ROOT_W - 1);
      op_d   = operand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      op_d = {op_q[grw_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[grw_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[grw_pkg::ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

@@ src/grw_ctrl.sv @@
// Controller state machine of the ray marcher: map clearing, march and distance sequencing.
// Depends on grw_pkg for the command and status structs.
module grw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             command_i,
  output logic             in_stall_o,
  input  grw_pkg::status_t status_i,
  output grw_pkg::cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_CHECK  = 9'b000000100,
    ST_TEST   = 9'b000001000,
    ST_SQ_X   = 9'b000010000,
    ST_SQ_Y   = 9'b000100000,
    ST_SQ_GO  = 9'b001000000,
    ST_SQRT   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i == grw_pkg::CMD_CAST) begin
            cmd_o.load = 1'b1;
            state_d    = ST_CHECK;
          end else begin
            cmd_o.wr_cell = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        // The map read for the current cell is issued in this cycle.
        if (status_i.in_map) begin
          state_d = ST_TEST;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_TEST: begin
        if (status_i.wall) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_SQ_X;
        end else if (status_i.limit) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_SQ_X: begin
        cmd_o.sq_x = 1'b1;
        state_d    = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd_o.sq_y = 1'b1;
        state_d    = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQRT;
      end
      ST_SQRT: begin
        if (!status_i.sqrt_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/grw_dp.sv @@
// Datapath of the ray marcher: configuration, wall map, march registers, distance and result.
// Depends on grw_pkg, grw_ram and grw_sqrt.
module grw_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  grw_pkg::cmd_t                      cmd_i,
  output grw_pkg::status_t                   status_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [19:0]                        cfg_data_i,
  input  logic [5:0]                         cell_col_i,
  input  logic [5:0]                         cell_row_i,
  input  logic                               is_wall_i,
  input  logic signed [20:0]                 start_x_i,
  input  logic signed [20:0]                 start_y_i,
  input  logic signed [20:0]                 step_x_i,
  input  logic signed [20:0]                 step_y_i,
  input  logic [15:0]                        ray_angle_i,
  input  logic                               vertical_hit_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [27:0]                        distance_o,
  output logic signed [14:0]                 end_col_o,
  output logic signed [14:0]                 end_row_o,
  output logic [13:0]                        hit_fraction_o,
  output logic [15:0]                        angle_out_o,
  output logic                               vertical_out_o
);

  localparam int unsigned CW = grw_pkg::COORD_W;
  localparam int unsigned CS = grw_pkg::CELL_SHIFT;

  // Configuration registers.
  logic [6:0]  map_w_q, map_h_q;
  logic [19:0] player_x_q, player_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q    <= 7'(grw_pkg::MAP_DIM);
      map_h_q    <= 7'(grw_pkg::MAP_DIM);
      player_x_q <= '0;
      player_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        grw_pkg::REG_MAP_WIDTH:  map_w_q    <= cfg_data_i[6:0];
        grw_pkg::REG_MAP_HEIGHT: map_h_q    <= cfg_data_i[6:0];
        grw_pkg::REG_PLAYER_X:   player_x_q <= cfg_data_i;
        grw_pkg::REG_PLAYER_Y:   player_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clearing pass address after reset.
  logic [grw_pkg::RAM_AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // March registers.
  logic signed [CW-1:0]     x_q, y_q;
  logic signed [20:0]       sx_q, sy_q;
  logic [grw_pkg::LIMIT_W-1:0] steps_q;
  logic                     hit_q;
  logic [15:0]              angle_q;
  logic                     vert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= 1'b0;
    end else if (cmd_i.set_hit) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= CW'(start_x_i);
      y_q     <= CW'(start_y_i);
      sx_q    <= step_x_i;
      sy_q    <= step_y_i;
      steps_q <= '0;
      angle_q <= ray_angle_i;
      vert_q  <= vertical_hit_i;
    end else if (cmd_i.step) begin
      x_q     <= x_q + CW'(sx_q);
      y_q     <= y_q + CW'(sy_q);
      steps_q <= steps_q + 1'b1;
    end
  end

  // Map bounds test on the current point; sizes above the map store saturate.
  logic [6:0] w_used, h_used, cx, cy;
  logic       in_map;

  always_comb begin
    w_used = (map_w_q > 7'(grw_pkg::MAP_DIM)) ? 7'(grw_pkg::MAP_DIM) : map_w_q;
    h_used = (map_h_q > 7'(grw_pkg::MAP_DIM)) ? 7'(grw_pkg::MAP_DIM) : map_h_q;
    cx     = x_q[CS+6:CS];
    cy     = y_q[CS+6:CS];
    in_map = !x_q[CW-1] && !y_q[CW-1] && (cx < w_used) && (cy < h_used);
  end

  // Wall map: cleared after reset, written by write transactions.
  logic                       ram_we;
  logic [grw_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
  logic                       ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = cmd_i.clr;
    ram_waddr = clr_addr_q;
    ram_wdata = 1'b0;
    if (cmd_i.wr_cell) begin
      ram_we    = ({1'b0, cell_col_i} < 7'(grw_pkg::MAP_DIM))
                  && ({1'b0, cell_row_i} < 7'(grw_pkg::MAP_DIM));
      ram_waddr = {cell_row_i, cell_col_i};
      ram_wdata = is_wall_i;
    end
    ram_raddr = {cy[grw_pkg::MAP_AW-1:0], cx[grw_pkg::MAP_AW-1:0]};
  end

  grw_ram #(
    .Width (1),
    .Depth (grw_pkg::RAM_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Squared distance components, one multiplication per cycle.
  logic signed [CW:0]        dx, dy;
  logic [grw_pkg::ABS_W-1:0] adx, ady, mul_a;
  logic [2*grw_pkg::ABS_W-1:0] sqa_q, sqb_q, prod;

  always_comb begin
    dx    = (CW+1)'($signed({1'b0, player_x_q})) - (CW+1)'(x_q);
    dy    = (CW+1)'($signed({1'b0, player_y_q})) - (CW+1)'(y_q);
    adx   = grw_pkg::ABS_W'(dx[CW] ? -dx : dx);
    ady   = grw_pkg::ABS_W'(dy[CW] ? -dy : dy);
    mul_a = cmd_i.sq_y ? ady : adx;
    prod  = mul_a * mul_a;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_x) begin
      sqa_q <= prod;
    end
    if (cmd_i.sq_y) begin
      sqb_q <= prod;
    end
  end

  logic [grw_pkg::SQ_W-1:0]   sq_sum;
  logic                       sqrt_busy;
  logic [grw_pkg::ROOT_W-1:0] root;

  assign sq_sum = grw_pkg::SQ_W'(sqa_q) + grw_pkg::SQ_W'(sqb_q);

  grw_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.sqrt_start),
    .operand_i (sq_sum),
    .busy_o    (sqrt_busy),
    .root_o    (root)
  );

  // Result fields from the final point.
  logic [CW-1:0]             ax, ay, af;
  logic [CW-CS-1:0]          qx, qy;
  logic [grw_pkg::DIST_W-1:0] dist_sel;

  always_comb begin
    ax = x_q[CW-1] ? CW'(-x_q) : CW'(x_q);
    ay = y_q[CW-1] ? CW'(-y_q) : CW'(y_q);
    af = vert_q ? ay : ax;
    qx = ax[CW-1:CS];
    qy = ay[CW-1:CS];
    if (!hit_q) begin
      dist_sel = grw_pkg::NO_HIT_DIST;
    end else if ({{(grw_pkg::DIST_W-grw_pkg::ROOT_W){1'b0}}, root} > grw_pkg::DIST_MAX) begin
      dist_sel = grw_pkg::DIST_MAX;
    end else begin
      dist_sel = grw_pkg::DIST_W'(root);
    end
  end

  // Output register; the input side stays free while a result waits.
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      distance_o     <= dist_sel;
      end_col_o      <= x_q[CW-1] ? -15'($signed({1'b0, qx})) : 15'($signed({1'b0, qx}));
      end_row_o      <= y_q[CW-1] ? -15'($signed({1'b0, qy})) : 15'($signed({1'b0, qy}));
      hit_fraction_o <= af[CS-1:0];
      angle_out_o    <= angle_q;
      vertical_out_o <= vert_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller.
  always_comb begin
    status_o.clr_last  = (clr_addr_q == '1);
    status_o.in_map    = in_map;
    status_o.wall      = ram_rdata;
    status_o.limit     = steps_q[grw_pkg::LIMIT_W-1];
    status_o.sqrt_busy = sqrt_busy;
    status_o.out_free  = out_free;
  end

endmodule

@@ src/grid_ray_wall_march.sv @@
// Top level of the grid ray wall marcher: controller and datapath.
// Depends on grw_pkg, grw_ctrl and grw_dp.
//
// After reset the block clears its 64 x 64 wall map, one cell a cycle, and
// takes no transaction meanwhile (configuration writes are taken at once).
// A cast is taken, then each march step reads the map and then tests for a
// wall. The march ends with a bounds test when the ray leaves the map, at
// the step limit, or with the read and wall test of the hit cell. On a hit
// the two squares and the iterative square root follow, which yields two
// radicand bits a cycle; then the result is loaded once the output register
// is free. One cast is in work at a time; a finished result waits in the
// output register while the next transaction is taken.
module grid_ray_wall_march (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [5:0]          cell_col_i,
  input  logic [5:0]          cell_row_i,
  input  logic                is_wall_i,
  input  logic signed [20:0]  start_x_i,
  input  logic signed [20:0]  start_y_i,
  input  logic signed [20:0]  step_x_i,
  input  logic signed [20:0]  step_y_i,
  input  logic [15:0]         ray_angle_i,
  input  logic                vertical_hit_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [27:0]         distance_o,
  output logic signed [14:0]  end_col_o,
  output logic signed [14:0]  end_row_o,
  output logic [13:0]         hit_fraction_o,
  output logic [15:0]         angle_out_o,
  output logic                vertical_out_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [19:0]         cfg_data_i
);

  grw_pkg::cmd_t    cmd;
  grw_pkg::status_t status;

  // Sequencer.
  grw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Map, march and result datapath.
  grw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cell_col_i     (cell_col_i),
    .cell_row_i     (cell_row_i),
    .is_wall_i      (is_wall_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .step_x_i       (step_x_i),
    .step_y_i       (step_y_i),
    .ray_angle_i    (ray_angle_i),
    .vertical_hit_i (vertical_hit_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .distance_o     (distance_o),
    .end_col_o      (end_col_o),
    .end_row_o      (end_row_o),
    .hit_fraction_o (hit_fraction_o),
    .angle_out_o    (angle_out_o),
    .vertical_out_o (vertical_out_o)
  );

endmodule

@@ dv/grw_checker.sv @@
// Scoreboard for the grid ray wall marcher: watches both channels and the register port.
// It predicts each cast result from its own copy of the map and registers.
// Depends on grw_pkg.
`timescale 1ns / 1ps

module grw_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               command_i,
  input  logic [5:0]         cell_col_i,
  input  logic [5:0]         cell_row_i,
  input  logic               is_wall_i,
  input  logic signed [20:0] start_x_i,
  input  logic signed [20:0] start_y_i,
  input  logic signed [20:0] step_x_i,
  input  logic signed [20:0] step_y_i,
  input  logic [15:0]        ray_angle_i,
  input  logic               vertical_hit_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [27:0]        distance_i,
  input  logic signed [14:0] end_col_i,
  input  logic signed [14:0] end_row_i,
  input  logic [13:0]        hit_fraction_i,
  input  logic [15:0]        angle_out_i,
  input  logic               vertical_out_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 waiting_o
);

  localparam longint CELL_UNITS  = 64'sd16384;
  localparam int     STEP_BUDGET = 65536;

  typedef struct packed {
    logic [27:0] distance;
    logic [14:0] end_col;
    logic [14:0] end_row;
    logic [13:0] hit_fraction;
    logic [15:0] angle;
    logic        vertical;
  } ray_result_t;

  // Shadow copy of the block's state.
  logic        wall_bits [grw_pkg::RAM_DEPTH];
  logic [6:0]  cols_reg;
  logic [6:0]  rows_reg;
  logic [19:0] eye_x;
  logic [19:0] eye_y;

  ray_result_t pending_rays[$];
  int          pending_count;
  int          mismatches;

  assign fail_count_o = mismatches;
  assign waiting_o    = pending_count;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // March the ray over the shadow map and form the expected result.
  function automatic ray_result_t march_ray(logic signed [20:0] sx0, logic signed [20:0] sy0,
                                            logic signed [20:0] dx0, logic signed [20:0] dy0,
                                            logic [15:0] ang, logic vert);
    ray_result_t res;
    longint x, y, dx, dy, w, h, ax;
    longint unsigned sq, root;
    int     steps;
    bit     hit;
    x = sx0; y = sy0; dx = dx0; dy = dy0;
    w = (cols_reg > grw_pkg::MAP_DIM) ? grw_pkg::MAP_DIM : cols_reg;
    h = (rows_reg > grw_pkg::MAP_DIM) ? grw_pkg::MAP_DIM : rows_reg;
    steps = 0;
    hit = 0;
    while (x >= 0 && y >= 0 && x / CELL_UNITS < w && y / CELL_UNITS < h) begin
      if (wall_bits[(y / CELL_UNITS) * grw_pkg::MAP_DIM + (x / CELL_UNITS)]) begin
        hit = 1;
        break;
      end
      if (steps >= STEP_BUDGET) break;
      x += dx;
      y += dy;
      steps++;
    end
    if (hit) begin
      sq = (longint'(eye_x) - x) * (longint'(eye_x) - x)
         + (longint'(eye_y) - y) * (longint'(eye_y) - y);
      root = floor_root(sq);
      res.distance = (root > 64'hFFFFFFF) ? grw_pkg::DIST_MAX : root[27:0];
    end else begin
      res.distance = grw_pkg::NO_HIT_DIST;
    end
    res.end_col = 15'(x / CELL_UNITS);
    res.end_row = 15'(y / CELL_UNITS);
    ax = vert ? ((y < 0) ? -y : y) : ((x < 0) ? -x : x);
    res.hit_fraction = 14'(((ax % CELL_UNITS) * 16384) / CELL_UNITS);
    res.angle    = ang;
    res.vertical = vert;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Track transactions on both channels and the register port.
  always @(posedge clk_i or negedge rst_ni) begin
    ray_result_t want;
    if (!rst_ni) begin
      cols_reg      = 7'd64;
      rows_reg      = 7'd64;
      eye_x         = '0;
      eye_y         = '0;
      mismatches    = 0;
      pending_count = 0;
      pending_rays.delete();
      for (int i = 0; i < grw_pkg::RAM_DEPTH; i++) wall_bits[i] = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          grw_pkg::REG_MAP_WIDTH:  cols_reg = cfg_data_i[6:0];
          grw_pkg::REG_MAP_HEIGHT: rows_reg = cfg_data_i[6:0];
          grw_pkg::REG_PLAYER_X:   eye_x    = cfg_data_i;
          grw_pkg::REG_PLAYER_Y:   eye_y    = cfg_data_i;
          default: ;
        endcase
      end
      // A result is compared before this edge's input changes the map.
      if (out_valid_i && !out_stall_i) begin
        if (pending_rays.size() == 0) begin
          report_mismatch("unexpected result, distance", distance_i, -1);
        end else begin
          want = pending_rays.pop_front();
          if (distance_i != want.distance)
            report_mismatch("distance", distance_i, want.distance);
          if (end_col_i != want.end_col)
            report_mismatch("end_col", end_col_i, $signed(want.end_col));
          if (end_row_i != want.end_row)
            report_mismatch("end_row", end_row_i, $signed(want.end_row));
          if (hit_fraction_i != want.hit_fraction)
            report_mismatch("hit_fraction", hit_fraction_i, want.hit_fraction);
          if (angle_out_i != want.angle)
            report_mismatch("angle_out", angle_out_i, want.angle);
          if (vertical_out_i != want.vertical)
            report_mismatch("vertical_out", vertical_out_i, want.vertical);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == grw_pkg::CMD_WRITE)
          wall_bits[cell_row_i * grw_pkg::MAP_DIM + cell_col_i] = is_wall_i;
        else
          pending_rays.push_back(march_ray(start_x_i, start_y_i, step_x_i, step_y_i,
                                           ray_angle_i, vertical_hit_i));
      end
      pending_count = pending_rays.size();
    end
  end

endmodule

@@ dv/tb_grid_ray_wall_march.sv @@
// Testbench top for the grid ray wall marcher: clock, reset, stimulus and verdict.
// Depends on grw_pkg, grid_ray_wall_march and grw_checker.
`timescale 1ns / 1ps

module tb_grid_ray_wall_march;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = grw_pkg::CMD_WRITE;
  logic [5:0]         cell_col_i = '0;
  logic [5:0]         cell_row_i = '0;
  logic               is_wall_i = 1'b0;
  logic signed [20:0] start_x_i = '0;
  logic signed [20:0] start_y_i = '0;
  logic signed [20:0] step_x_i = '0;
  logic signed [20:0] step_y_i = '0;
  logic [15:0]        ray_angle_i = '0;
  logic               vertical_hit_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [27:0]        distance_o;
  logic signed [14:0] end_col_o;
  logic signed [14:0] end_row_o;
  logic [13:0]        hit_fraction_o;
  logic [15:0]        angle_out_o;
  logic               vertical_out_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [19:0]        cfg_data_i = '0;

  int fail_count;
  int rays_waiting;
  bit calm = 1'b0;
  int sent = 0;
  int used_cols = 64;
  int used_rows = 64;

  grid_ray_wall_march uut (.*);

  grw_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .cell_col_i,
    .cell_row_i, .is_wall_i, .start_x_i, .start_y_i, .step_x_i, .step_y_i, .ray_angle_i,
    .vertical_hit_i, .out_valid_i(out_valid_o), .out_stall_i, .distance_i(distance_o),
    .end_col_i(end_col_o), .end_row_i(end_row_o), .hit_fraction_i(hit_fraction_o),
    .angle_out_i(angle_out_o), .vertical_out_i(vertical_out_o), .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .waiting_o(rays_waiting)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver stalls at random outside the calm stretch.
  always @(negedge clk_i) out_stall_i = !calm && ($urandom_range(99) < 33);

  // Hand one transaction to the block and wait for it to be taken.
  task automatic offer(logic cmd, logic [5:0] col, logic [5:0] row, logic wall,
                       logic [20:0] sx, logic [20:0] sy, logic [20:0] dx, logic [20:0] dy,
                       logic [15:0] ang, logic vert);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    command_i = cmd; cell_col_i = col; cell_row_i = row; is_wall_i = wall;
    start_x_i = sx; start_y_i = sy; step_x_i = dx; step_y_i = dy;
    ray_angle_i = ang; vertical_hit_i = vert;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic put_cell(int col, int row, bit wall);
    offer(grw_pkg::CMD_WRITE, 6'(col), 6'(row), wall, 21'($urandom), 21'($urandom),
          21'($urandom), 21'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic cast(int sx, int sy, int dx, int dy, logic [15:0] ang, bit vert);
    offer(grw_pkg::CMD_CAST, 6'($urandom), 6'($urandom), 1'($urandom), 21'(sx), 21'(sy),
          21'(dx), 21'(dy), ang, vert);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (rays_waiting != 0) @(negedge clk_i);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic set_reg(logic [1:0] idx, int val);
    drain();
    repeat (64) @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = 20'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == grw_pkg::REG_MAP_WIDTH)  used_cols = (val[6:0] > 64) ? 64 : val[6:0];
    if (idx == grw_pkg::REG_MAP_HEIGHT) used_rows = (val[6:0] > 64) ? 64 : val[6:0];
  endtask

  function automatic int pick_step();
    int mag;
    if ($urandom_range(99) < 12) return $urandom;
    mag = $urandom_range(4096, 1048575);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // Mostly rays starting inside the used map, walls written where rays go.
  task automatic random_phase(int n);
    int sx, sy;
    for (int i = 0; i < n; i++) begin
      calm = (sent >= 300 && sent < 420);
      if (sent == 500) drain();
      if ($urandom_range(99) < 30) begin
        if (used_cols > 0 && used_rows > 0 && $urandom_range(9) < 8)
          put_cell($urandom_range(used_cols - 1), $urandom_range(used_rows - 1),
                   $urandom_range(99) < 60);
        else
          put_cell($urandom, $urandom, 1'($urandom));
      end else begin
        if (used_cols > 0 && used_rows > 0 && $urandom_range(99) < 85) begin
          sx = $urandom_range(used_cols * 16384 - 1);
          sy = $urandom_range(used_rows * 16384 - 1);
        end else begin
          sx = $urandom; sy = $urandom;
        end
        cast(sx, sy, pick_step(), pick_step(), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: open map, corner walls, exits on each side, endless march.
    cast(0, 0, 1048575, 1048575, 16'h0000, 1'b0);
    put_cell(63, 63, 1'b1);
    put_cell(0, 0, 1'b1);
    cast(0, 0, 1000, 1000, 16'hFFFF, 1'b1);
    cast(63 * 16384 + 100, 63 * 16384 + 200, 0, 0, 16'h1234, 1'b1);
    put_cell(5, 0, 1'b1);
    put_cell(0, 0, 1'b0);
    cast(0, 100, 16384, 0, 16'hFFFF, 1'b1);
    cast(-1048576, -1048576, 1048575, 1048575, 16'h8000, 1'b0);
    cast(1048575, 1048575, -1048576, -1048576, 16'h00FF, 1'b1);
    cast(500000, 3000, -1048576, -7, 16'h0F0F, 1'b0);
    cast(100, 100, 0, 0, 16'hAAAA, 1'b0);

    set_reg(grw_pkg::REG_PLAYER_X, 20'hFFFFF);
    set_reg(grw_pkg::REG_PLAYER_Y, 20'hFFFFF);
    cast(63 * 16384, 10, 1, 16384, 16'h5555, 1'b1);
    set_reg(grw_pkg::REG_MAP_WIDTH, 0);
    cast(0, 0, 16384, 16384, 16'h0001, 1'b0);
    set_reg(grw_pkg::REG_MAP_WIDTH, 127);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 127);
    cast(62 * 16384, 62 * 16384, 16384, 16384, 16'h7FFF, 1'b1);
    set_reg(grw_pkg::REG_MAP_WIDTH, 1);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 1);
    put_cell(0, 0, 1'b1);
    cast(16383, 16383, 1, 1, 16'hC000, 1'b0);

    // Random phases over a spread of map sizes and player positions.
    random_phase(60);
    set_reg(grw_pkg::REG_MAP_WIDTH, 64);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 64);
    set_reg(grw_pkg::REG_PLAYER_X, $urandom_range(20'hFFFFF));
    set_reg(grw_pkg::REG_PLAYER_Y, $urandom_range(20'hFFFFF));
    random_phase(260);
    set_reg(grw_pkg::REG_MAP_WIDTH, 17);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 40);
    set_reg(grw_pkg::REG_PLAYER_X, 0);
    random_phase(180);
    set_reg(grw_pkg::REG_MAP_WIDTH, 127);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 3);
    set_reg(grw_pkg::REG_PLAYER_Y, 0);
    random_phase(140);
    set_reg(grw_pkg::REG_MAP_WIDTH, 0);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 64);
    random_phase(40);
    set_reg(grw_pkg::REG_MAP_WIDTH, 64);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 0);
    random_phase(30);
    set_reg(grw_pkg::REG_MAP_HEIGHT, 64);
    set_reg(grw_pkg::REG_PLAYER_X, $urandom_range(20'hFFFFF));
    random_phase(90);

    drain();
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
